[design/rlfi_pkg.sv]
// Shared types, constants and codes for the request latency fault injector.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package rlfi_pkg;

    // Request payloads.
    typedef struct packed {
        logic        func;
        logic [63:0] now_ticks;
        logic [31:0] ticket_in;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [31:0] ticket_out;
        logic        expired;
    } t_out_item;

    // Request kinds.
    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    // Configuration register indexes.
    localparam int          CFG_IDX_W        = 3;
    localparam logic [2:0]  CFG_MIN_LATENCY  = 3'd0;
    localparam logic [2:0]  CFG_MAX_LATENCY  = 3'd1;
    localparam logic [2:0]  CFG_FAIL_PERCENT = 3'd2;
    localparam logic [2:0]  CFG_FAIL_SEED    = 3'd3;
    localparam logic [2:0]  CFG_TICKS_PER_S  = 3'd4;

    // Configuration reset values.
    localparam logic signed [16:0] RST_MIN_LATENCY  = 17'sd0;
    localparam logic signed [16:0] RST_MAX_LATENCY  = 17'sd0;
    localparam logic [6:0]         RST_FAIL_PERCENT = 7'd0;
    localparam logic [31:0]        RST_FAIL_STATE   = 32'd1;
    localparam logic [31:0]        RST_TICKS_PER_S  = 32'd1000000;

    // Arithmetic constants.
    localparam logic [31:0] FAIL_MULT     = 32'hac564b05;
    localparam logic [63:0] HASH_MULT     = 64'h369dea0f31a53f85;
    localparam logic [31:0] HASH_MULT_LO  = HASH_MULT[31:0];
    localparam logic [31:0] HASH_MULT_HI  = HASH_MULT[63:32];
    localparam logic [7:0]  FAIL_SCALE_D  = 8'hff;
    localparam logic [6:0]  FAIL_SCALE_N  = 7'd100;
    localparam logic [15:0] MS_PER_SECOND = 16'd1000;

    // Reciprocal of 1000: (x * RECIP_MS) >> RECIP_SHIFT is floor(x / 1000) for any 32-bit x.
    localparam logic [31:0] RECIP_MS    = 32'd274877907;
    localparam int          RECIP_SHIFT = 38;

    // Remainder divider: 64-bit dividend, 16-bit divisor, two quotient bits a cycle.
    localparam int DIV_W         = 64;
    localparam int DIV_BITS_STEP = 2;
    localparam int DIV_STEPS     = DIV_W / DIV_BITS_STEP;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FAIL_MUL,
        S_DECIDE,
        S_HASH0,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_MOD,
        S_SCALE,
        S_SCALE_LO,
        S_RECIP,
        S_TICKET,
        S_DONE
    } t_state;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_FAIL_MUL,
        OP_DECIDE,
        OP_HASH0,
        OP_HASH1,
        OP_HASH2,
        OP_HASH3,
        OP_DIV_STEP,
        OP_SCALE,
        OP_SCALE_LO,
        OP_RECIP,
        OP_TICKET,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_check;
        logic fail_en;
        logic refuse;
        logic lat_off;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

[design/rlfi_ctrl.sv]
// Sequencing state machine of the request latency fault injector.
// Depends on rlfi_pkg; drives operation commands into rlfi_dpath.
`timescale 1ns / 1ps

module rlfi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rlfi_pkg::t_dp_sts i_sts,
    output rlfi_pkg::t_dp_cmd o_cmd
);
    import rlfi_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_sts.in_check) begin
                        n_state = S_CHECK;
                    end else if (i_sts.fail_en) begin
                        n_state = S_FAIL_MUL;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_state  = S_DONE;
            end
            S_FAIL_MUL: begin
                o_cmd.op = OP_FAIL_MUL;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.op = OP_DECIDE;
                n_state  = (i_sts.refuse || i_sts.lat_off) ? S_DONE : S_HASH0;
            end
            S_HASH0: begin
                o_cmd.op = OP_HASH0;
                n_state  = S_HASH1;
            end
            S_HASH1: begin
                o_cmd.op = OP_HASH1;
                n_state  = S_HASH2;
            end
            S_HASH2: begin
                o_cmd.op = OP_HASH2;
                n_state  = S_HASH3;
            end
            S_HASH3: begin
                o_cmd.op = OP_HASH3;
                n_state  = S_MOD;
            end
            S_MOD: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_state  = S_SCALE_LO;
            end
            S_SCALE_LO: begin
                o_cmd.op = OP_SCALE_LO;
                n_state  = S_RECIP;
            end
            S_RECIP: begin
                o_cmd.op = OP_RECIP;
                n_state  = S_TICKET;
            end
            S_TICKET: begin
                o_cmd.op = OP_TICKET;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A result is only moved to the output register when that register is free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_EMIT) |-> i_sts.out_free)
        else $error("result emitted while the output register is occupied");

    // An accepted request always leaves the controller busy in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("controller ready again right after accepting a request");

endmodule

[design/rlfi_dpath.sv]
// Datapath of the request latency fault injector: configuration, state,
// shared 32x32 multiplier, radix-4 divider and result registers. Uses rlfi_pkg.
`timescale 1ns / 1ps

module rlfi_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rlfi_pkg::t_in_item                 i_in,
    output rlfi_pkg::t_out_item                o_out,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic                               i_cfg_valid,
    input  logic [rlfi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  rlfi_pkg::t_dp_cmd                  i_cmd,
    output rlfi_pkg::t_dp_sts                  o_sts
);
    import rlfi_pkg::*;

    // Configuration and persistent state.
    logic signed [16:0] r_min_lat;
    logic signed [16:0] r_max_lat;
    logic [6:0]         r_fail_pct;
    logic [31:0]        r_tps;
    logic [31:0]        r_fail_state;
    logic [63:0]        r_base;
    logic               r_base_cap;
    logic               r_out_valid;

    // Working registers of one request.
    logic [63:0]          r_now;
    logic [31:0]          r_tkt;
    logic [63:0]          r_prod;
    logic [63:0]          r_acc;
    logic [63:0]          r_dvd;
    logic [15:0]          r_rem;
    logic [15:0]          r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [15:0]          r_lo;
    logic [15:0]          r_spread;
    logic [31:0]          r_tq;
    logic [31:0]          r_tr;
    t_out_item            r_res;
    t_out_item            r_out;

    // Latency bound normalization from the current registers.
    logic [15:0] norm_lo;
    logic [15:0] norm_hi;
    always_comb begin
        if (r_min_lat < 0) begin
            norm_lo = '0;
            norm_hi = '0;
        end else if (r_max_lat < 0) begin
            norm_lo = r_min_lat[15:0];
            norm_hi = r_min_lat[15:0];
        end else if (r_min_lat > r_max_lat) begin
            norm_lo = r_max_lat[15:0];
            norm_hi = r_min_lat[15:0];
        end else begin
            norm_lo = r_min_lat[15:0];
            norm_hi = r_max_lat[15:0];
        end
    end

    // Failure draw: floor(byte * 100 / 255) < percent is byte * 100 < percent * 255.
    logic [15:0] fail_lhs;
    logic [15:0] fail_rhs;
    assign fail_lhs = 16'(r_fail_state[7:0]) * 16'(FAIL_SCALE_N);
    assign fail_rhs = 16'(r_fail_pct) * 16'(FAIL_SCALE_D);

    // Shared multiplier with operands chosen by the current operation.
    // The tick rate is split into a quotient and a remainder of 1000 while the
    // multiplier is otherwise idle, so the scaled latency needs no divider.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [16:0] bias_ms;
    always_comb begin
        case (i_cmd.op)
            OP_FAIL_MUL: begin
                mul_a = r_fail_state;
                mul_b = FAIL_MULT;
            end
            OP_DECIDE: begin
                mul_a = r_tps;
                mul_b = RECIP_MS;
            end
            OP_HASH0: begin
                mul_a = r_now[31:0];
                mul_b = HASH_MULT_LO;
            end
            OP_HASH1: begin
                mul_a = r_now[63:32];
                mul_b = HASH_MULT_LO;
            end
            OP_HASH2: begin
                mul_a = r_now[31:0];
                mul_b = HASH_MULT_HI;
            end
            OP_HASH3: begin
                mul_a = r_tq;
                mul_b = 32'(MS_PER_SECOND);
            end
            OP_SCALE: begin
                mul_a = 32'(bias_ms);
                mul_b = r_tq;
            end
            OP_SCALE_LO: begin
                mul_a = 32'(bias_ms);
                mul_b = r_tr;
            end
            OP_RECIP: begin
                mul_a = r_prod[31:0];
                mul_b = RECIP_MS;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Latency in ms: hashed remainder (zero for an empty spread) plus the lower bound.
    assign bias_ms = {1'b0, (r_spread == '0) ? 16'd0 : r_rem} + {1'b0, r_lo};

    // One divider step retires two quotient bits.
    logic [16:0] div_t1;
    logic [16:0] div_t2;
    logic [15:0] div_s1;
    logic [15:0] div_s2;
    logic        div_q1;
    logic        div_q2;
    always_comb begin
        div_t1 = {r_rem, r_dvd[DIV_W-1]};
        div_q1 = (div_t1 >= {1'b0, r_dvs});
        div_s1 = div_q1 ? 16'(div_t1 - {1'b0, r_dvs}) : div_t1[15:0];
        div_t2 = {div_s1, r_dvd[DIV_W-2]};
        div_q2 = (div_t2 >= {1'b0, r_dvs});
        div_s2 = div_q2 ? 16'(div_t2 - {1'b0, r_dvs}) : div_t2[15:0];
    end

    // Expiry compare for check requests.
    logic [63:0] deadline;
    logic        check_done;
    assign deadline   = r_base + {32'd0, r_tkt};
    assign check_done = (r_tkt == '0) || ($signed(r_now) >= $signed(deadline));

    // Status towards the controller.
    always_comb begin
        o_sts.in_check = (i_in.func == FUNC_CHECK);
        o_sts.fail_en  = (r_fail_pct != '0);
        o_sts.refuse   = (r_fail_pct != '0) && (fail_lhs < fail_rhs);
        o_sts.lat_off  = (norm_hi == '0);
        o_sts.div_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // Configuration, failure state, time base and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_lat    <= RST_MIN_LATENCY;
            r_max_lat    <= RST_MAX_LATENCY;
            r_fail_pct   <= RST_FAIL_PERCENT;
            r_tps        <= RST_TICKS_PER_S;
            r_fail_state <= RST_FAIL_STATE;
            r_base       <= '0;
            r_base_cap   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_LATENCY:  r_min_lat    <= $signed(i_cfg_data[16:0]);
                    CFG_MAX_LATENCY:  r_max_lat    <= $signed(i_cfg_data[16:0]);
                    CFG_FAIL_PERCENT: r_fail_pct   <= i_cfg_data[6:0];
                    CFG_FAIL_SEED:    r_fail_state <= i_cfg_data | 32'd1;
                    CFG_TICKS_PER_S:  r_tps        <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == OP_FAIL_MUL) begin
                r_fail_state <= mul_p[31:0];
            end
            if (i_cmd.op == OP_DECIDE && !o_sts.refuse && !o_sts.lat_off
                && !r_base_cap) begin
                r_base     <= r_now;
                r_base_cap <= 1'b1;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_now <= i_in.now_ticks;
                r_tkt <= i_in.ticket_in;
            end
            OP_CHECK: begin
                r_res.accepted   <= 1'b0;
                r_res.ticket_out <= '0;
                r_res.expired    <= check_done;
            end
            OP_DECIDE: begin
                r_lo             <= norm_lo;
                r_spread         <= norm_hi - norm_lo;
                r_tq             <= 32'(mul_p[63:RECIP_SHIFT]);
                r_res.accepted   <= !o_sts.refuse;
                r_res.ticket_out <= '0;
                r_res.expired    <= 1'b0;
            end
            OP_HASH0: begin
                r_prod <= mul_p;
            end
            OP_HASH1: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            OP_HASH2: begin
                r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                r_prod       <= mul_p;
            end
            OP_HASH3: begin
                // Low 64 bits of the hash product go to the divider as dividend.
                r_dvd <= {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
                r_dvs <= r_spread;
                r_rem <= '0;
                r_cnt <= '0;
                r_tr  <= r_tps - mul_p[31:0];
            end
            OP_DIV_STEP: begin
                r_dvd <= {r_dvd[DIV_W-3:0], div_q1, div_q2};
                r_rem <= div_s2;
                r_cnt <= r_cnt + 1'b1;
            end
            OP_SCALE: begin
                // Latency times the whole thousands of the tick rate.
                r_acc <= mul_p;
            end
            OP_SCALE_LO: begin
                // Latency times the leftover ticks, the tick rate modulo MS_PER_SECOND.
                r_prod <= mul_p;
            end
            OP_RECIP: begin
                r_dvd <= r_acc + 64'(mul_p[63:RECIP_SHIFT]);
            end
            OP_TICKET: begin
                r_res.ticket_out <= r_now[31:0] + r_dvd[31:0] - r_base[31:0];
            end
            OP_EMIT: begin
                r_out <= r_res;
            end
            default: begin
            end
        endcase
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    // The failure state is odd after reset and stays odd under the odd multiplier.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail_state[0])
        else $error("failure state lost its low bit");

    // Once captured, the time base stays captured and unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base_cap |=> (r_base_cap && $stable(r_base)))
        else $error("time base changed after capture");

endmodule

[design/request_latency_fault_injector_unit.sv]
// Top level of the request latency fault injector.
// Depends on rlfi_pkg, rlfi_ctrl and rlfi_dpath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in  (t_in_item)
//  out     | output    | o_out_valid/i_out_ready | o_out (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request at a time. A check passes from the accepting state through S_CHECK to
// the output register; a begin goes through S_DECIDE (after S_FAIL_MUL when a fail
// percent is set) and on to S_DONE when refused or without latency; otherwise it goes
// on through the hash steps, the 32-step pass of the radix-4 divider (hash modulo
// spread), the multiplier steps that scale the latency to ticks, and S_TICKET.
// Reset is synchronous and active low; it restores the configuration defaults.
// A result waits in the output register while the next request is accepted; a full
// output register holds the finished request until the receiver takes the old one.
// Configuration writes are always taken.
`timescale 1ns / 1ps

module request_latency_fault_injector_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rlfi_pkg::t_in_item             i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rlfi_pkg::t_out_item            o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rlfi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import rlfi_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration writes never stall.
    assign o_cfg_ready = 1'b1;

    rlfi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rlfi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

[sim/request_latency_fault_injector_unit_test.sv]
// Self-checking testbench for request_latency_fault_injector_unit.
// Needs rlfi_pkg and the design files. Directed requests come first, then random
// requests under four pacing modes, checked against the plan or a predictor in this file.
`timescale 1ns / 1ps

module request_latency_fault_injector_unit_test;
    import rlfi_pkg::*;

    // Predictor constants, kept apart from the design package on purpose.
    localparam logic [31:0] FAIL_STEP = 32'hac564b05;
    localparam logic [63:0] HASH_STEP = 64'h369dea0f31a53f85;

    typedef enum {PACE_STEADY, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} t_pace;
    typedef enum {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        t_in_item    req;
        bit          known;
        t_out_item   want;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_req;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [31:0] cfg_data;

    // Predictor copy of the registers and the injector state.
    logic signed [16:0] min_ms;
    logic signed [16:0] max_ms;
    logic [6:0]  fail_pct;
    logic [31:0] fail_seed;
    logic [31:0] tick_rate;
    logic [31:0] fail_state;
    logic [63:0] time_base;
    logic        base_valid;

    t_out_item   pending_outcomes[$];
    logic [31:0] issued_tickets[$];
    t_row        plan[$];
    logic [63:0] now_clock;

    int send_idle_pct;
    int recv_stall_pct;
    int fault_count;
    int n_begins, n_refused, n_delayed, n_checks, n_expired, n_writes;

    request_latency_fault_injector_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Overall time limit.
    initial begin
        #2_000_000;
        $display("request_latency_fault_injector_unit_test: done, errors");
        $finish;
    end

    // Register state right after reset.
    function automatic void reset_model();
        min_ms     = 17'sd0;
        max_ms     = 17'sd0;
        fail_pct   = 7'd0;
        fail_seed  = 32'd1;
        tick_rate  = 32'd1000000;
        fail_state = 32'd1;
        time_base  = 64'd0;
        base_valid = 1'b0;
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [31:0] val);
        case (idx)
            CFG_MIN_LATENCY:  min_ms = val[16:0];
            CFG_MAX_LATENCY:  max_ms = val[16:0];
            CFG_FAIL_PERCENT: fail_pct = val[6:0];
            CFG_FAIL_SEED: begin
                fail_seed  = val;
                fail_state = val | 32'd1;
            end
            CFG_TICKS_PER_S:  tick_rate = val;
            default: ;
        endcase
    endfunction

    // Works out the result of one request and advances the predictor state.
    function automatic t_out_item predict_outcome(t_in_item req);
        t_out_item   res;
        logic [63:0] deadline;
        logic [63:0] spread;
        logic [63:0] delay;
        logic [31:0] scaled;
        int          lo;
        int          hi;
        int          swap;
        res = '0;
        if (req.func == FUNC_CHECK) begin
            deadline    = time_base + {32'd0, req.ticket_in};
            res.expired = (req.ticket_in == 32'd0) ||
                          ($signed(req.now_ticks) >= $signed(deadline));
            n_checks++;
            if (res.expired) n_expired++;
            return res;
        end
        n_begins++;

        // The failure draw only happens when a fail percent is set.
        if (fail_pct != 7'd0) begin
            fail_state = fail_state * FAIL_STEP;
            scaled = ({24'd0, fail_state[7:0]} * 32'd100) / 32'd255;
            if (scaled < {25'd0, fail_pct}) begin
                n_refused++;
                return res;
            end
        end

        // Normalize the latency bounds.
        lo = min_ms;
        hi = max_ms;
        if (lo < 0) begin
            lo = 0;
            hi = 0;
        end else if (hi < 0) begin
            hi = lo;
        end else if (lo > hi) begin
            swap = lo;
            lo = hi;
            hi = swap;
        end
        res.accepted = 1'b1;
        if (hi <= 0) return res;

        if (!base_valid) begin
            time_base  = req.now_ticks;
            base_valid = 1'b1;
        end
        spread = 64'(hi - lo);
        delay  = (spread != 64'd0) ? (req.now_ticks * HASH_STEP) % spread : 64'd0;
        delay  = delay + 64'(lo);
        delay  = delay * {32'd0, tick_rate};
        delay  = delay / 64'd1000;
        res.ticket_out = 32'(req.now_ticks + delay - time_base);
        n_delayed++;
        return res;
    endfunction

    function automatic t_out_item outcome(logic acc, logic [31:0] tkt, logic exp);
        t_out_item o;
        o.accepted   = acc;
        o.ticket_out = tkt;
        o.expired    = exp;
        return o;
    endfunction

    function automatic t_row request_row(logic func, logic [63:0] now, logic [31:0] tkt);
        t_row r;
        r.kind          = ROW_REQ;
        r.reg_idx       = CFG_MIN_LATENCY;
        r.reg_val       = 32'd0;
        r.req.func      = func;
        r.req.now_ticks = now;
        r.req.ticket_in = tkt;
        r.known         = 1'b0;
        r.want          = '0;
        return r;
    endfunction

    function automatic t_row known_row(logic func, logic [63:0] now, logic [31:0] tkt,
                                       t_out_item want);
        t_row r;
        r       = request_row(func, now, tkt);
        r.known = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row register_row(logic [2:0] idx, logic [31:0] val);
        t_row r;
        r         = request_row(FUNC_BEGIN, 64'd0, 32'd0);
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Directed requests: reset defaults, check edge cases, bound handling, failures.
    function automatic void build_plan();
        // Defaults: no latency, no failure, no time base yet.
        plan.push_back(known_row(FUNC_BEGIN, 64'd0, 32'd0, outcome(1'b1, 32'd0, 1'b0)));
        plan.push_back(known_row(FUNC_CHECK, 64'd0, 32'd0, outcome(1'b0, 32'd0, 1'b1)));
        plan.push_back(known_row(FUNC_CHECK, 64'd4, 32'd5, outcome(1'b0, 32'd0, 1'b0)));
        plan.push_back(known_row(FUNC_CHECK, 64'd5, 32'd5, outcome(1'b0, 32'd0, 1'b1)));
        // A negative now compares below any deadline near a zero base.
        plan.push_back(known_row(FUNC_CHECK, '1, 32'hffff_ffff,
                                 outcome(1'b0, 32'd0, 1'b0)));
        plan.push_back(known_row(FUNC_CHECK, 64'h7fff_ffff_ffff_ffff, 32'd1,
                                 outcome(1'b0, 32'd0, 1'b1)));
        plan.push_back(known_row(FUNC_BEGIN, '1, 32'hffff_ffff,
                                 outcome(1'b1, 32'd0, 1'b0)));
        // A fail percent above 100 refuses every begin.
        plan.push_back(register_row(CFG_FAIL_PERCENT, 32'd127));
        plan.push_back(known_row(FUNC_BEGIN, 64'd123, 32'd0, outcome(1'b0, 32'd0, 1'b0)));
        // Latency on: the first begin at time zero captures the base.
        plan.push_back(register_row(CFG_FAIL_PERCENT, 32'd0));
        plan.push_back(register_row(CFG_MIN_LATENCY, 32'd10));
        plan.push_back(register_row(CFG_MAX_LATENCY, 32'd20));
        plan.push_back(request_row(FUNC_BEGIN, 64'd0, 32'd0));
        plan.push_back(request_row(FUNC_BEGIN, 64'd1_000_000, 32'd0));
        plan.push_back(known_row(FUNC_CHECK, 64'd5000, 32'd10000,
                                 outcome(1'b0, 32'd0, 1'b0)));
        plan.push_back(known_row(FUNC_CHECK, 64'd10000, 32'd10000,
                                 outcome(1'b0, 32'd0, 1'b1)));
        // A negative minimum disables latency, down to the most negative value.
        plan.push_back(register_row(CFG_MIN_LATENCY, 32'hffff_ffff));
        plan.push_back(known_row(FUNC_BEGIN, 64'd777, 32'd0, outcome(1'b1, 32'd0, 1'b0)));
        plan.push_back(register_row(CFG_MIN_LATENCY, 32'hffff_0000));
        plan.push_back(known_row(FUNC_BEGIN, 64'd900, 32'd0, outcome(1'b1, 32'd0, 1'b0)));
        // A negative maximum follows the minimum; reversed bounds are swapped.
        plan.push_back(register_row(CFG_MIN_LATENCY, 32'd30));
        plan.push_back(register_row(CFG_MAX_LATENCY, 32'hffff_ffff));
        plan.push_back(request_row(FUNC_BEGIN, 64'd2_000_000, 32'd0));
        plan.push_back(register_row(CFG_MIN_LATENCY, 32'd65535));
        plan.push_back(register_row(CFG_MAX_LATENCY, 32'd0));
        plan.push_back(request_row(FUNC_BEGIN, 64'h0123_4567_89ab_cdef, 32'd0));
        // A zero tick rate gives zero delay; the largest rate with the largest bounds.
        plan.push_back(register_row(CFG_TICKS_PER_S, 32'd0));
        plan.push_back(request_row(FUNC_BEGIN, 64'hfedc_ba98_7654_3210, 32'd0));
        plan.push_back(register_row(CFG_TICKS_PER_S, 32'hffff_ffff));
        plan.push_back(register_row(CFG_MAX_LATENCY, 32'd65535));
        plan.push_back(request_row(FUNC_BEGIN, 64'd3_000_000, 32'd0));
        // Failure draws from an all-ones seed and from a seed with bit zero clear.
        plan.push_back(register_row(CFG_FAIL_SEED, 32'hffff_ffff));
        plan.push_back(register_row(CFG_FAIL_PERCENT, 32'd100));
        plan.push_back(request_row(FUNC_BEGIN, 64'd3_100_000, 32'd0));
        plan.push_back(request_row(FUNC_BEGIN, 64'd3_200_000, 32'd0));
        plan.push_back(request_row(FUNC_BEGIN, 64'd3_300_000, 32'd0));
        plan.push_back(register_row(CFG_FAIL_SEED, 32'd0));
        plan.push_back(register_row(CFG_FAIL_PERCENT, 32'd1));
        plan.push_back(request_row(FUNC_BEGIN, 64'd3_400_000, 32'd0));
        // Zero bounds: latency off again without a negative minimum.
        plan.push_back(register_row(CFG_FAIL_PERCENT, 32'd0));
        plan.push_back(register_row(CFG_MIN_LATENCY, 32'd0));
        plan.push_back(register_row(CFG_MAX_LATENCY, 32'd0));
        plan.push_back(known_row(FUNC_BEGIN, 64'd3_500_000, 32'd0,
                                 outcome(1'b1, 32'd0, 1'b0)));
    endfunction

    function automatic logic [31:0] draw_latency();
        case ($urandom_range(9))
            0:       return 32'hffff_ffff;
            1:       return $urandom;
            2:       return 32'd0;
            7:       return $urandom_range(0, 65535);
            8:       return 32'd65535;
            9:       return $urandom_range(1, 2000);
            default: return $urandom_range(0, 50);
        endcase
    endfunction

    function automatic logic [31:0] draw_fail_percent();
        case ($urandom_range(7))
            3, 4:    return $urandom_range(1, 40);
            5:       return $urandom_range(41, 100);
            6:       return 32'd100;
            7:       return $urandom_range(101, 127);
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] draw_tick_rate();
        case ($urandom_range(6))
            0:       return 32'd1;
            1:       return 32'd1000;
            4:       return $urandom;
            5:       return 32'hffff_ffff;
            6:       return $urandom_range(1, 100000);
            default: return 32'd1000000;
        endcase
    endfunction

    // Random request: mostly begins on a running clock and checks of issued tickets
    // near their deadlines, with some wholly random times and tickets.
    function automatic t_in_item next_random_request();
        t_in_item    r;
        logic [63:0] nudge;
        now_clock = now_clock + 64'($urandom_range(0, 300000));
        if ($urandom_range(19) == 0) now_clock = {$urandom, $urandom};
        r.now_ticks = now_clock;
        r.ticket_in = $urandom;
        if ($urandom_range(9) < 6) begin
            r.func = FUNC_BEGIN;
            return r;
        end
        r.func = FUNC_CHECK;
        case ($urandom_range(9))
            0:       r.ticket_in = 32'd0;
            1, 2:    r.ticket_in = $urandom;
            default: if (issued_tickets.size() != 0)
                r.ticket_in = issued_tickets[$urandom_range(0, issued_tickets.size() - 1)];
        endcase
        if ($urandom_range(1) == 0) begin
            nudge = 64'($urandom_range(0, 4)) - 64'd2;
            r.now_ticks = time_base + {32'd0, r.ticket_in} + nudge;
        end
        return r;
    endfunction

    function automatic void set_pace(t_pace pace);
        case (pace)
            PACE_SENDER_IDLE: begin
                send_idle_pct  = 84;
                recv_stall_pct = 0;
            end
            PACE_RECEIVER_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 84;
            end
            PACE_BOTH: begin
                send_idle_pct  = 28;
                recv_stall_pct = 28;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    // Presents one request, waits for it to be taken and records its expected result.
    // Called and returning at a falling edge; valid stays high for a back-to-back request.
    task automatic drive_request(t_in_item req, bit known, t_out_item want);
        t_out_item pred;
        int        gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_req   = req;
        do @(posedge clk); while (!in_ready);
        pred = predict_outcome(req);
        pending_outcomes.push_back(known ? want : pred);
        if (req.func == FUNC_BEGIN && pred.ticket_out != 32'd0) begin
            issued_tickets.push_back(pred.ticket_out);
            if (issued_tickets.size() > 8) void'(issued_tickets.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_idx   = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, val);
        n_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drops valid and waits until every request has returned its result.
    task automatic settle();
        in_valid = 1'b0;
        while (pending_outcomes.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Receiver pacing.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker.
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with no request pending: %h", out_res);
                fault_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (out_res.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted,
                           out_res.accepted);
                    fault_count++;
                end
                if (out_res.ticket_out !== want.ticket_out) begin
                    $error("ticket_out: expected %h, got %h", want.ticket_out,
                           out_res.ticket_out);
                    fault_count++;
                end
                if (out_res.expired !== want.expired) begin
                    $error("expired: expected %0d, got %0d", want.expired,
                           out_res.expired);
                    fault_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        t_in_item req;
        int       phase;
        int       n;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        cfg_valid = 1'b0;
        cfg_idx   = '0;
        cfg_data  = 32'd0;
        out_ready = 1'b0;
        now_clock = 64'd4_000_000;
        fault_count = 0;
        n_begins  = 0;
        n_refused = 0;
        n_delayed = 0;
        n_checks  = 0;
        n_expired = 0;
        n_writes  = 0;
        set_pace(PACE_STEADY);
        reset_model();
        build_plan();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part.
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle();
                write_register(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                drive_request(plan[i].req, plan[i].known, plan[i].want);
            end
        end

        // Random part: a fresh register setting and pacing mode per phase.
        for (phase = 0; phase < 8; phase++) begin
            settle();
            set_pace(t_pace'(phase % 4));
            write_register(CFG_MIN_LATENCY, draw_latency());
            write_register(CFG_MAX_LATENCY, draw_latency());
            write_register(CFG_FAIL_PERCENT, draw_fail_percent());
            write_register(CFG_FAIL_SEED, $urandom);
            write_register(CFG_TICKS_PER_S, draw_tick_rate());
            for (n = 0; n < 54; n++) begin
                req = next_random_request();
                drive_request(req, 1'b0, '0);
            end
        end

        settle();
        repeat (80) @(posedge clk);
        $display("Covered %0d begins (%0d refused, %0d with a deadline) and %0d checks",
                 n_begins, n_refused, n_delayed, n_checks);
        $display("(%0d expired), with %0d register writes under four pacing modes.",
                 n_expired, n_writes);
        if (fault_count == 0) begin
            $display("request_latency_fault_injector_unit_test: done, clean");
        end else begin
            $display("request_latency_fault_injector_unit_test: done, errors");
        end
        $finish;
    end

endmodule
